>>> design/cau_pkg.sv
// ----------------------------------------------------------------------------
// cau_pkg
// Shared operation codes and control types of the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

    localparam int MODE_W = 3;

    typedef enum logic [MODE_W-1:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_NEG = 3'd4,
        OP_EQ  = 3'd5,
        OP_NE  = 3'd6,
        OP_NOP = 3'd7
    } op_t;

    // classification that travels with every item from front to back
    typedef struct packed {
        op_t  op;
        logic eq;
    } ctl_t;

    localparam int CTL_W = $bits(ctl_t);

endpackage

>>> design/cau_front.sv
// ----------------------------------------------------------------------------
// cau_front
// Input stage: takes an item, decodes the mode and resolves the comparison.
// ----------------------------------------------------------------------------
module cau_front
    import cau_pkg::*;
#(
    parameter int W  = 32,
    parameter int QW = CTL_W + 4 * W
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [MODE_W-1:0]    mode,
    input  logic signed [W-1:0]  a_re,
    input  logic signed [W-1:0]  a_im,
    input  logic signed [W-1:0]  b_re,
    input  logic signed [W-1:0]  b_im,
    output logic                 fq_valid,
    input  logic                 fq_ready,
    output logic [QW-1:0]        fq_data
);

    logic         f_v_reg;
    ctl_t         f_ctl_reg;
    logic [W-1:0] f_ar_reg, f_ai_reg, f_br_reg, f_bi_reg;
    ctl_t         ctl_next;

    assign in_ready = !f_v_reg || fq_ready;

    always_comb
    begin
        ctl_next.op = op_t'(mode);
        ctl_next.eq = (a_re == b_re) && (a_im == b_im);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_v_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            f_v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            f_ctl_reg <= ctl_next;
            f_ar_reg  <= a_re;
            f_ai_reg  <= a_im;
            f_br_reg  <= b_re;
            f_bi_reg  <= b_im;
        end
    end

    assign fq_valid = f_v_reg;
    assign fq_data  = {f_ctl_reg, f_ar_reg, f_ai_reg, f_br_reg, f_bi_reg};

endmodule

>>> design/cau_queue.sv
// ----------------------------------------------------------------------------
// cau_queue
// Two-entry item queue between front and back.
// ----------------------------------------------------------------------------
module cau_queue #(
    parameter int QW = 132
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  logic [QW-1:0] wr_data,
    output logic          rd_valid,
    input  logic          rd_ready,
    output logic [QW-1:0] rd_data
);

    logic [QW-1:0] mem_reg [0:1];
    logic          wp_reg, rp_reg;
    logic [1:0]    cnt_reg;
    logic          wr, rd;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign wr       = wr_valid && wr_ready;
    assign rd       = rd_valid && rd_ready;
    assign rd_data  = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr)
            begin
                wp_reg <= !wp_reg;
            end
            if (rd)
            begin
                rp_reg <= !rp_reg;
            end
            if (wr && !rd)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (rd && !wr)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

endmodule

>>> design/cau_back.sv
// ----------------------------------------------------------------------------
// cau_back
// Execution pipeline: products, sums, restoring divider stages, clamp.
// ----------------------------------------------------------------------------
module cau_back
    import cau_pkg::*;
#(
    parameter int W  = 32,
    parameter int F  = 16,
    parameter int QW = CTL_W + 4 * W
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  logic [QW-1:0]        q_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [W-1:0]         res_re,
    output logic [W-1:0]         res_im,
    output logic                 compare_true,
    output logic                 div_zero,
    output logic                 saturated
);

    localparam int PW = 2 * W;        // product width
    localparam int MW = 2 * W + 1;    // sum of two products
    localparam int NB = MW + F;       // dividend / quotient width
    localparam int VW = NB + 1;       // signed final value

    function automatic logic [W:0] clamp_f(input logic signed [VW-1:0] v);
        logic [W:0] r;
        if ((&v[VW-1:W-1]) || !(|v[VW-1:W-1]))
            r = {1'b0, v[W-1:0]};
        else if (v[VW-1])
            r = {1'b1, 1'b1, {(W-1){1'b0}}};
        else
            r = {1'b1, 1'b0, {(W-1){1'b1}}};
        return r;
    endfunction

    logic adv;
    logic ov_reg;
    assign adv     = !ov_reg || out_ready;
    assign q_ready = adv;

    // unpack queue item
    ctl_t                q_ctl;
    logic signed [W-1:0] q_ar, q_ai, q_br, q_bi;
    assign {q_ctl, q_ar, q_ai, q_br, q_bi} = q_data;

    // stage 1: products and short sums
    logic                 s1_v_reg;
    ctl_t                 s1_ctl_reg;
    logic signed [PW-1:0] s1_prr_reg, s1_pii_reg, s1_pri_reg, s1_pir_reg;
    logic signed [PW-1:0] s1_pbr_reg, s1_pbi_reg;
    logic signed [W:0]    s1_as_re_reg, s1_as_im_reg;
    logic signed [W:0]    as_re_next, as_im_next;

    always_comb
    begin
        unique case (q_ctl.op)
            OP_ADD:
            begin
                as_re_next = (W+1)'(q_ar) + (W+1)'(q_br);
                as_im_next = (W+1)'(q_ai) + (W+1)'(q_bi);
            end
            OP_SUB:
            begin
                as_re_next = (W+1)'(q_ar) - (W+1)'(q_br);
                as_im_next = (W+1)'(q_ai) - (W+1)'(q_bi);
            end
            OP_NEG:
            begin
                as_re_next = -(W+1)'(q_ar);
                as_im_next = -(W+1)'(q_ai);
            end
            default:
            begin
                as_re_next = '0;
                as_im_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_v_reg <= q_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_ctl_reg   <= q_ctl;
            s1_prr_reg   <= q_ar * q_br;
            s1_pii_reg   <= q_ai * q_bi;
            s1_pri_reg   <= q_ar * q_bi;
            s1_pir_reg   <= q_ai * q_br;
            s1_pbr_reg   <= q_br * q_br;
            s1_pbi_reg   <= q_bi * q_bi;
            s1_as_re_reg <= as_re_next;
            s1_as_im_reg <= as_im_next;
        end
    end

    // stage 2: wide sums, divisor, dividend magnitude
    logic signed [MW-1:0] mre, mim, dre, dim;
    logic [PW-1:0]        den;
    logic [MW-1:0]        mag_re, mag_im;
    logic [NB-1:0]        nq_re_next, nq_im_next;

    assign mre    = MW'(s1_prr_reg) - MW'(s1_pii_reg);
    assign mim    = MW'(s1_pri_reg) + MW'(s1_pir_reg);
    assign dre    = MW'(s1_prr_reg) + MW'(s1_pii_reg);
    assign dim    = MW'(s1_pir_reg) - MW'(s1_pri_reg);
    assign den    = s1_pbr_reg[PW-1:0] + s1_pbi_reg[PW-1:0];
    assign mag_re = dre[MW-1] ? MW'(-dre) : MW'(dre);
    assign mag_im = dim[MW-1] ? MW'(-dim) : MW'(dim);

    always_comb
    begin
        unique case (s1_ctl_reg.op)
            OP_MUL:
            begin
                nq_re_next = NB'(mre >>> F);
                nq_im_next = NB'(mim >>> F);
            end
            OP_DIV:
            begin
                nq_re_next = NB'(mag_re) << F;
                nq_im_next = NB'(mag_im) << F;
            end
            OP_ADD, OP_SUB, OP_NEG:
            begin
                nq_re_next = NB'(s1_as_re_reg);
                nq_im_next = NB'(s1_as_im_reg);
            end
            default:
            begin
                nq_re_next = '0;
                nq_im_next = '0;
            end
        endcase
    end

    // divider pipeline, index 0 is the stage 2 output
    logic          d_v_reg   [0:NB];
    ctl_t          d_ctl_reg [0:NB];
    logic          d_dz_reg  [0:NB];
    logic          d_nre_reg [0:NB];
    logic          d_nim_reg [0:NB];
    logic [PW-1:0] d_den_reg [0:NB];
    logic [PW-1:0] d_rre_reg [0:NB];
    logic [PW-1:0] d_rim_reg [0:NB];
    logic [NB-1:0] d_qre_reg [0:NB];
    logic [NB-1:0] d_qim_reg [0:NB];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_v_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            d_v_reg[0] <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_ctl_reg[0] <= s1_ctl_reg;
            d_dz_reg[0]  <= (den == '0);
            d_nre_reg[0] <= dre[MW-1];
            d_nim_reg[0] <= dim[MW-1];
            d_den_reg[0] <= den;
            d_rre_reg[0] <= '0;
            d_rim_reg[0] <= '0;
            d_qre_reg[0] <= nq_re_next;
            d_qim_reg[0] <= nq_im_next;
        end
    end

    for (genvar k = 0; k < NB; k++)
    begin : g_div
        logic [PW:0] t_re, t_im;
        logic        ge_re, ge_im, run;

        assign run   = (d_ctl_reg[k].op == OP_DIV) && !d_dz_reg[k];
        assign t_re  = {d_rre_reg[k], d_qre_reg[k][NB-1]};
        assign t_im  = {d_rim_reg[k], d_qim_reg[k][NB-1]};
        assign ge_re = t_re >= {1'b0, d_den_reg[k]};
        assign ge_im = t_im >= {1'b0, d_den_reg[k]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                d_v_reg[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                d_v_reg[k+1] <= d_v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                d_ctl_reg[k+1] <= d_ctl_reg[k];
                d_dz_reg[k+1]  <= d_dz_reg[k];
                d_nre_reg[k+1] <= d_nre_reg[k];
                d_nim_reg[k+1] <= d_nim_reg[k];
                d_den_reg[k+1] <= d_den_reg[k];
                if (run)
                begin
                    d_rre_reg[k+1] <= ge_re ? PW'(t_re - {1'b0, d_den_reg[k]}) : PW'(t_re);
                    d_rim_reg[k+1] <= ge_im ? PW'(t_im - {1'b0, d_den_reg[k]}) : PW'(t_im);
                    d_qre_reg[k+1] <= {d_qre_reg[k][NB-2:0], ge_re};
                    d_qim_reg[k+1] <= {d_qim_reg[k][NB-2:0], ge_im};
                end
                else
                begin
                    d_rre_reg[k+1] <= d_rre_reg[k];
                    d_rim_reg[k+1] <= d_rim_reg[k];
                    d_qre_reg[k+1] <= d_qre_reg[k];
                    d_qim_reg[k+1] <= d_qim_reg[k];
                end
            end
        end
    end

    // final: sign fix-up, clamp, output register
    logic signed [VW-1:0] pos_re, pos_im, fv_re, fv_im;
    logic [W:0]           cl_re, cl_im;
    ctl_t                 f_ctl;
    logic [W-1:0]         re_next, im_next;
    logic                 cmp_next, dz_next, sat_next;

    assign f_ctl  = d_ctl_reg[NB];
    assign pos_re = $signed({1'b0, d_qre_reg[NB]});
    assign pos_im = $signed({1'b0, d_qim_reg[NB]});

    always_comb
    begin
        if (f_ctl.op == OP_DIV)
        begin
            fv_re = d_nre_reg[NB] ? -pos_re : pos_re;
            fv_im = d_nim_reg[NB] ? -pos_im : pos_im;
        end
        else
        begin
            fv_re = VW'($signed(d_qre_reg[NB]));
            fv_im = VW'($signed(d_qim_reg[NB]));
        end
    end

    assign cl_re = clamp_f(fv_re);
    assign cl_im = clamp_f(fv_im);

    always_comb
    begin
        re_next  = '0;
        im_next  = '0;
        cmp_next = 1'b0;
        dz_next  = 1'b0;
        sat_next = 1'b0;
        unique case (f_ctl.op)
            OP_ADD, OP_SUB, OP_MUL, OP_NEG:
            begin
                re_next  = cl_re[W-1:0];
                im_next  = cl_im[W-1:0];
                sat_next = cl_re[W] || cl_im[W];
            end
            OP_DIV:
            begin
                if (d_dz_reg[NB])
                begin
                    dz_next = 1'b1;
                end
                else
                begin
                    re_next  = cl_re[W-1:0];
                    im_next  = cl_im[W-1:0];
                    sat_next = cl_re[W] || cl_im[W];
                end
            end
            OP_EQ:   cmp_next = f_ctl.eq;
            OP_NE:   cmp_next = !f_ctl.eq;
            OP_NOP:  cmp_next = 1'b0;
            default: cmp_next = 1'b0;
        endcase
    end

    logic [W-1:0] re_reg, im_reg;
    logic         cmp_reg, dz_reg, sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (adv)
        begin
            ov_reg <= d_v_reg[NB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            re_reg  <= re_next;
            im_reg  <= im_next;
            cmp_reg <= cmp_next;
            dz_reg  <= dz_next;
            sat_reg <= sat_next;
        end
    end

    assign out_valid    = ov_reg;
    assign res_re       = re_reg;
    assign res_im       = im_reg;
    assign compare_true = cmp_reg;
    assign div_zero     = dz_reg;
    assign saturated    = sat_reg;

endmodule

>>> design/complex_arith_unit.sv
// ----------------------------------------------------------------------------
// complex_arith_unit
// Complex add, subtract, multiply, divide, negate and compare on Q-format data.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel in_valid/in_ready carries one item: mode plus the operand
//    parts a_re, a_im, b_re, b_im (signed, FRAC_BITS fraction bits).
//  - Output channel out_valid/out_ready carries one result item per input
//    item, in order: res_re, res_im, compare_true, div_zero, saturated.
//  - Throughput: one item per cycle when the receiver keeps out_ready high.
//  - Every mode takes the same path: front register, queue and the back
//    pipeline with the restoring divider, which resolves one quotient bit
//    per stage.
//  - Reset (rst_n low) empties the front register, the queue and the back
//    pipeline; no result is pending afterwards.
//  - When the receiver stalls the whole back pipeline holds, the two-entry
//    queue fills, then the front register, and in_ready drops.
//  - A divide by zero returns zero parts with div_zero set.
// ----------------------------------------------------------------------------
module complex_arith_unit
    import cau_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [MODE_W-1:0]             mode,
    input  logic signed [DATA_WIDTH-1:0]  a_re,
    input  logic signed [DATA_WIDTH-1:0]  a_im,
    input  logic signed [DATA_WIDTH-1:0]  b_re,
    input  logic signed [DATA_WIDTH-1:0]  b_im,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [DATA_WIDTH-1:0]  res_re,
    output logic signed [DATA_WIDTH-1:0]  res_im,
    output logic                          compare_true,
    output logic                          div_zero,
    output logic                          saturated
);

    // queued item: classification plus the four operand parts
    localparam int QW = CTL_W + 4 * DATA_WIDTH;

    logic          fq_valid, fq_ready;
    logic [QW-1:0] fq_data;
    logic          qb_valid, qb_ready;
    logic [QW-1:0] qb_data;

    // front: accept and decode
    cau_front #(
        .W  (DATA_WIDTH),
        .QW (QW)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .mode     (mode),
        .a_re     (a_re),
        .a_im     (a_im),
        .b_re     (b_re),
        .b_im     (b_im),
        .fq_valid (fq_valid),
        .fq_ready (fq_ready),
        .fq_data  (fq_data)
    );

    // decoupling queue
    cau_queue #(
        .QW (QW)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_data  (fq_data),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_data  (qb_data)
    );

    // back: arithmetic pipeline with output register
    cau_back #(
        .W  (DATA_WIDTH),
        .F  (FRAC_BITS),
        .QW (QW)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (qb_valid),
        .q_ready      (qb_ready),
        .q_data       (qb_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .res_re       (res_re),
        .res_im       (res_im),
        .compare_true (compare_true),
        .div_zero     (div_zero),
        .saturated    (saturated)
    );

endmodule

>>> design/cau_checker.sv
// ----------------------------------------------------------------------------
// cau_checker
// Port-level checks of the complex arithmetic unit, bound to the top level.
// ----------------------------------------------------------------------------
module cau_checker
    import cau_pkg::*;
#(
    parameter int DATA_WIDTH = 32
)
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [DATA_WIDTH-1:0] res_re,
    input logic [DATA_WIDTH-1:0] res_im,
    input logic                  compare_true,
    input logic                  div_zero,
    input logic                  saturated
);

    localparam logic [DATA_WIDTH-1:0] MAXV = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] MINV = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(res_re) && $stable(res_im)
            && $stable(compare_true) && $stable(div_zero) && $stable(saturated))
        else $error("stalled result changed");

    // zero divisor gives zero parts and no clamp
    a_dz: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && div_zero |-> res_re == '0 && res_im == '0 && !saturated
            && !compare_true)
        else $error("div_zero result not clean");

    // comparison results carry no arithmetic
    a_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && compare_true |-> res_re == '0 && res_im == '0 && !saturated)
        else $error("compare result not clean");

    // a clamped result shows a limit in some part
    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |-> res_re == MAXV || res_re == MINV
            || res_im == MAXV || res_im == MINV)
        else $error("saturated without limit value");

endmodule

bind complex_arith_unit cau_checker #(.DATA_WIDTH(DATA_WIDTH)) u_cau_checker (.*);

>>> dv/complex_arith_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// complex_arith_unit_test
// Drives random and corner operand pairs through the complex arithmetic unit
// and checks every result item against an in-bench model of the arithmetic.
// ----------------------------------------------------------------------------

module complex_arith_unit_test;
    import cau_pkg::*;

    localparam int DW       = 32;
    localparam int FB       = 16;
    localparam int LATENCY  = 2 * DW + FB + 6;
    localparam int WD_LIMIT = 20 * LATENCY + 2000;
    localparam int N_RAND   = 1150;

    typedef logic signed [DW-1:0] word_t;
    // wide enough for the shifted divide numerator (2*DW+FB+1 bits)
    typedef logic signed [2*DW+FB+3:0] wide_t;

    typedef struct packed {
        word_t re;
        word_t im;
        logic  cmp;
        logic  dz;
        logic  sat;
    } cau_res_t;

    // ------------------------------------------------------------------------
    // Result model and in-order store of expected result items
    // ------------------------------------------------------------------------
    class cau_scoreboard;
        cau_res_t pending[$];
        int       errors;

        function new();
            errors = 0;
        endfunction

        // clamp an exact value to DW bits, noting any clamp
        static function word_t clamp(wide_t v, ref logic sat);
            wide_t hi;
            wide_t lo;
            hi = wide_t'(word_t'({1'b0, {(DW-1){1'b1}}}));
            lo = -hi - 1;
            if (v > hi)
            begin
                sat = 1'b1;
                return hi[DW-1:0];
            end
            if (v < lo)
            begin
                sat = 1'b1;
                return lo[DW-1:0];
            end
            return v[DW-1:0];
        endfunction

        // signed divide truncating toward zero
        static function wide_t div_trunc(wide_t n, wide_t d);
            wide_t q;
            q = (n < 0 ? -n : n) / d;
            return n < 0 ? -q : q;
        endfunction

        static function cau_res_t compute(op_t op, word_t ar, word_t ai,
                                          word_t br, word_t bi);
            cau_res_t r;
            wide_t    xr, xi, den;
            logic     arith;
            logic     eq;
            logic     sat;
            r     = '0;
            arith = 1'b1;
            sat   = 1'b0;
            xr    = '0;
            xi    = '0;
            eq    = (ar == br) && (ai == bi);
            case (op)
                OP_ADD:
                begin
                    xr = wide_t'(ar) + wide_t'(br);
                    xi = wide_t'(ai) + wide_t'(bi);
                end
                OP_SUB:
                begin
                    xr = wide_t'(ar) - wide_t'(br);
                    xi = wide_t'(ai) - wide_t'(bi);
                end
                OP_MUL:
                begin
                    xr = (wide_t'(ar) * wide_t'(br) - wide_t'(ai) * wide_t'(bi)) >>> FB;
                    xi = (wide_t'(ar) * wide_t'(bi) + wide_t'(ai) * wide_t'(br)) >>> FB;
                end
                OP_DIV:
                begin
                    den = wide_t'(br) * wide_t'(br) + wide_t'(bi) * wide_t'(bi);
                    if (den == 0)
                    begin
                        r.dz  = 1'b1;
                        arith = 1'b0;
                    end
                    else
                    begin
                        xr = div_trunc((wide_t'(ar) * wide_t'(br)
                                        + wide_t'(ai) * wide_t'(bi)) <<< FB, den);
                        xi = div_trunc((wide_t'(ai) * wide_t'(br)
                                        - wide_t'(ar) * wide_t'(bi)) <<< FB, den);
                    end
                end
                OP_NEG:
                begin
                    xr = -wide_t'(ar);
                    xi = -wide_t'(ai);
                end
                OP_EQ:
                begin
                    r.cmp = eq;
                    arith = 1'b0;
                end
                OP_NE:
                begin
                    r.cmp = !eq;
                    arith = 1'b0;
                end
                default:
                    arith = 1'b0;
            endcase
            if (arith)
            begin
                r.re  = clamp(xr, sat);
                r.im  = clamp(xi, sat);
                r.sat = sat;
            end
            return r;
        endfunction

        function void note_item(op_t op, word_t ar, word_t ai, word_t br, word_t bi);
            pending.push_back(compute(op, ar, ai, br, bi));
        endfunction

        function void check_result(cau_res_t got);
            cau_res_t exp;
            if (pending.size() == 0)
            begin
                $error("result item with nothing expected: re=%h im=%h", got.re, got.im);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.re !== exp.re)
            begin
                $error("res_re: expected %h, got %h", exp.re, got.re);
                errors++;
            end
            if (got.im !== exp.im)
            begin
                $error("res_im: expected %h, got %h", exp.im, got.im);
                errors++;
            end
            if (got.cmp !== exp.cmp)
            begin
                $error("compare_true: expected %b, got %b", exp.cmp, got.cmp);
                errors++;
            end
            if (got.dz !== exp.dz)
            begin
                $error("div_zero: expected %b, got %b", exp.dz, got.dz);
                errors++;
            end
            if (got.sat !== exp.sat)
            begin
                $error("saturated: expected %b, got %b", exp.sat, got.sat);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, DUT
    // ------------------------------------------------------------------------
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [2:0]  mode = '0;
    word_t       a_re = '0, a_im = '0, b_re = '0, b_im = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    word_t       res_re, res_im;
    logic        compare_true, div_zero, saturated;

    always #2 clk = ~clk;

    complex_arith_unit #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .mode(mode), .a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im),
        .out_valid(out_valid), .out_ready(out_ready),
        .res_re(res_re), .res_im(res_im), .compare_true(compare_true),
        .div_zero(div_zero), .saturated(saturated)
    );

    cau_scoreboard sb = new();

    // idling is off during the quiet window so long back-to-back runs occur
    logic quiet = 1'b0;
    int   stall_cnt = 0;

    // ------------------------------------------------------------------------
    // Monitor: both channels sampled at the rising edge
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_item(op_t'(mode), a_re, a_im, b_re, b_im);
            if (out_valid && out_ready)
                sb.check_result('{res_re, res_im, compare_true, div_zero, saturated});
            if ((in_valid && in_ready) || (out_valid && out_ready)
                || (!in_valid && sb.pending.size() == 0))
                stall_cnt <= 0;
            else
                stall_cnt <= stall_cnt + 1;
        end
    end

    // receiver: random back-pressure
    always @(posedge clk)
    begin
        if (rst_n)
            out_ready <= quiet || ($urandom_range(99) >= 12);
    end

    // watchdog: no progress for too long
    always @(posedge clk)
    begin
        if (stall_cnt >= WD_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------------
    // present one item, hold it until accepted; valid stays high for back-to-back
    task automatic send_item(op_t op, word_t ar, word_t ai, word_t br, word_t bi);
        while (!quiet && $urandom_range(99) < 12)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= op;
        a_re     <= ar;
        a_im     <= ai;
        b_re     <= br;
        b_im     <= bi;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    // random operand part: corners, small Q16.16 values, or full range
    function automatic word_t rand_part();
        case ($urandom_range(9))
            0: return word_t'({1'b1, {(DW-1){1'b0}}});
            1: return word_t'({1'b0, {(DW-1){1'b1}}});
            2: return '0;
            3, 4, 5: return word_t'($signed($urandom_range(32'h00FF_FFFF))) - 32'sh0080_0000;
            default: return word_t'($urandom);
        endcase
    endfunction

    localparam word_t MAXV = {1'b0, {(DW-1){1'b1}}};
    localparam word_t MINV = {1'b1, {(DW-1){1'b0}}};
    localparam word_t ONE  = 32'sh0001_0000;

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        op_t   op;
        word_t ar, ai, br, bi;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: every operation, extremes, zero divisor, negate of minimum,
        // comparison of equal/unequal pairs, the no-op code
        send_item(OP_ADD, MAXV, MINV, MAXV, MINV);
        send_item(OP_SUB, MINV, MAXV, MAXV, MINV);
        send_item(OP_MUL, MAXV, MAXV, MAXV, MINV);
        send_item(OP_MUL, MINV, MINV, MINV, MINV);
        send_item(OP_MUL, -ONE, 32'sh0000_8000, 32'sh0000_0001, -ONE);
        send_item(OP_DIV, ONE, ONE, '0, '0);
        send_item(OP_DIV, MAXV, MINV, 32'sh0000_0001, '0);
        send_item(OP_DIV, MINV, MINV, MINV, MINV);
        send_item(OP_DIV, -ONE, ONE, 32'sh0003_0000, -32'sh0002_0000);
        send_item(OP_NEG, MINV, MINV, '0, '0);
        send_item(OP_NEG, MAXV, '0, MAXV, MAXV);
        send_item(OP_EQ, MINV, MAXV, MINV, MAXV);
        send_item(OP_EQ, MINV, MAXV, MINV, MAXV - 1);
        send_item(OP_NE, ONE, '0, ONE, '0);
        send_item(OP_NE, ONE, '0, ONE, 32'sh0000_0001);
        send_item(OP_NOP, MAXV, MINV, ONE, -ONE);
        send_item(OP_ADD, '0, '0, '1, '1);

        // pause until every result is back
        drain();

        for (int i = 0; i < N_RAND; i++)
        begin
            quiet = (i >= 300 && i < 500);
            op = op_t'($urandom_range(7));
            ar = rand_part();
            ai = rand_part();
            br = rand_part();
            bi = rand_part();
            if ((op == OP_EQ || op == OP_NE) && $urandom_range(1))
            begin
                br = ar;
                bi = ai;
            end
            if (op == OP_DIV && $urandom_range(15) == 0)
            begin
                br = '0;
                bi = '0;
            end
            send_item(op, ar, ai, br, bi);
        end
        quiet = 1'b0;
        drain();
        repeat (LATENCY + 10) @(posedge clk);

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> complex_arith_unit.f
design/cau_pkg.sv
design/cau_front.sv
design/cau_queue.sv
design/cau_back.sv
design/complex_arith_unit.sv
design/cau_checker.sv
dv/complex_arith_unit_test.sv
